@@ design/rgm_pkg.sv @@
// rgm_pkg: shared types and constants for the resource grant manager
// no dependencies

package rgm_pkg;

  localparam int SLOTS      = 16;
  localparam int KINDS      = 10;
  localparam int COUNT_BITS = 8;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int KIND_BITS  = 4;
  localparam int HELD_DEPTH = SLOTS * KINDS;
  localparam int HELD_BITS  = $clog2(HELD_DEPTH);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    CMD_LAUNCH    = 3'd0,
    CMD_TICK      = 3'd1,
    CMD_REQUEST   = 3'd2,
    CMD_RELEASE   = 3'd3,
    CMD_TERMINATE = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    EV_LAUNCHED  = 4'd0,
    EV_FULL      = 4'd1,
    EV_GRANTED   = 4'd2,
    EV_BLOCKED   = 4'd3,
    EV_RELEASED  = 4'd4,
    EV_REL_IGN   = 4'd5,
    EV_TERM      = 4'd6,
    EV_UNBLOCK   = 4'd7,
    EV_SCHED     = 4'd8,
    EV_NONE      = 4'd9,
    EV_REJECT    = 4'd10
  } event_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HELD_RD,
    ST_HELD_WAIT,
    ST_HELD_WR,
    ST_CLEAR,
    ST_UNBLK,
    ST_UNBLK_RD,
    ST_UNBLK_WR,
    ST_SCHED,
    ST_OUT
  } state_t;

endpackage

@@ design/resource_grant_manager.sv @@
// resource_grant_manager: slot table and counted resource pool, top level
// depends on rgm_pkg
//
// usage: input items (cmd, slot, kind) arrive on in_valid / in_ready, each
// produces one or more result items on out_valid / out_ready; last marks
// the final result of an item. a small sequencer walks the slots and the
// kinds in turn, and the per-slot held counts live in a 160-entry
// memory with one port and registered read data.
// steps with no stall: a reject, a full table or a block goes straight to
// its result; a grant or a release reads, waits and writes its held
// count; launch zeroes ten held counts one a cycle; terminate reads,
// waits and writes each of the ten kinds in turn. tick walks the sixteen
// slots one a cycle, each unblock grant adding a read, a wait and a write
// with its result, then loads the next pick and searches up to sixteen
// slots from it. one item is in work at a time; in_ready is low until its
// last result is taken and rises the cycle after.
// reset: synchronous, clears slot flags and next pick, reloads available
// counts with 20; held counts are zeroed by a clearing pass over all 160
// entries after reset, during which no item is taken.
// stall: a result waits in the output register while out_ready is low and
// the sequencer holds. instances_per_kind writes (cfg_we) reload every
// available count at once.

module resource_grant_manager (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] cmd,
  input  logic [3:0] slot,
  input  logic [3:0] kind,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] event_res,
  output logic [3:0] which_slot,
  output logic [3:0] which_kind,
  output logic       last,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int SB = rgm_pkg::SLOT_BITS;
  localparam int KB = rgm_pkg::KIND_BITS;
  localparam int CB = rgm_pkg::COUNT_BITS;
  localparam int HB = rgm_pkg::HELD_BITS;

  rgm_pkg::state_t state, state_next;

  // slot table
  logic [rgm_pkg::SLOTS-1:0] occupied, blocked;
  logic [KB-1:0] wanted_kind [rgm_pkg::SLOTS];
  logic [CB-1:0] available_count [rgm_pkg::KINDS];
  logic [SB-1:0] next_pick;

  // held count memory
  logic [CB-1:0] held_mem [rgm_pkg::HELD_DEPTH];
  logic [HB-1:0] mem_addr;
  logic          mem_we;
  logic [CB-1:0] mem_wdata, mem_rdata;

  // captured item
  logic [2:0]  cur_cmd;
  logic [SB-1:0] cur_slot;
  logic [KB-1:0] cur_kind;

  // walk counters
  logic [HB:0]   clr_cnt;
  logic [KB-1:0] kcnt;
  logic [SB:0]   scnt;
  logic [SB-1:0] sidx;

  // pending result and the state after it is taken
  logic [3:0] r_ev, r_slot, r_kind;
  logic       r_last;
  rgm_pkg::state_t after_out;

  logic [HB-1:0] addr_sk;
  logic          found_free;
  logic [SB-1:0] free_idx;
  logic [CB:0]   sum_sat;
  logic [CB-1:0] cfg_sat;

  assign addr_sk = HB'(cur_slot * rgm_pkg::KINDS) + HB'(kcnt);

  always_comb begin
    found_free = 1'b0;
    free_idx   = '0;
    for (int i = rgm_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!occupied[i]) begin
        found_free = 1'b1;
        free_idx   = SB'(i);
      end
    end
  end

  assign cfg_sat = (CB >= 8) ? CB'(cfg_wdata) :
                   ((cfg_wdata > 8'(rgm_pkg::COUNT_MAX)) ? rgm_pkg::COUNT_MAX : CB'(cfg_wdata));

  always_ff @(posedge clk) begin
    if (mem_we) held_mem[mem_addr] <= mem_wdata;
    mem_rdata <= held_mem[mem_addr];
  end

  assign in_ready  = (state == rgm_pkg::ST_IDLE);
  assign out_valid = (state == rgm_pkg::ST_OUT);
  assign event_res  = r_ev;
  assign which_slot = r_slot;
  assign which_kind = r_kind;
  assign last       = r_last;

  always_ff @(posedge clk) begin
    state <= state_next;
  end

  // sequencer: one memory access or one slot step per cycle while no result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied   <= '0;
      blocked    <= '0;
      next_pick  <= '0;
      clr_cnt    <= '0;
      cur_cmd    <= 3'(rgm_pkg::CMD_LAUNCH);
      for (int k = 0; k < rgm_pkg::KINDS; k++) available_count[k] <= CB'(20);
      for (int s = 0; s < rgm_pkg::SLOTS; s++) wanted_kind[s] <= '0;
    end
    if (!rst && cfg_we) begin
      for (int k = 0; k < rgm_pkg::KINDS; k++) available_count[k] <= cfg_sat;
    end
    if (!rst) begin
      case (state)
        rgm_pkg::ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        rgm_pkg::ST_IDLE: begin
          if (in_valid) begin
            cur_cmd  <= cmd;
            cur_slot <= SB'(slot);
            cur_kind <= kind;
            kcnt     <= '0;
            scnt     <= '0;
            sidx     <= '0;
            r_last   <= 1'b1;
            r_kind   <= '0;
            r_slot   <= slot;
            case (cmd)
              rgm_pkg::CMD_LAUNCH: begin
                if (!found_free) begin
                  r_ev <= rgm_pkg::EV_FULL;
                  r_slot <= '0;
                end else begin
                  cur_slot <= free_idx;
                  occupied[free_idx] <= 1'b1;
                  blocked[free_idx]  <= 1'b0;
                  wanted_kind[free_idx] <= '0;
                  r_ev <= rgm_pkg::EV_LAUNCHED;
                  r_slot <= 4'(free_idx);
                end
              end
              rgm_pkg::CMD_TICK: ;
              rgm_pkg::CMD_REQUEST, rgm_pkg::CMD_RELEASE: begin
                kcnt <= kind;
                if (!occupied[SB'(slot)] || kind >= KB'(rgm_pkg::KINDS) ||
                    blocked[SB'(slot)]) begin
                  r_ev <= rgm_pkg::EV_REJECT;
                end else if (cmd == rgm_pkg::CMD_REQUEST &&
                             available_count[kind] == '0) begin
                  blocked[SB'(slot)] <= 1'b1;
                  wanted_kind[SB'(slot)] <= kind;
                  r_ev <= rgm_pkg::EV_BLOCKED;
                  r_kind <= kind;
                end
              end
              rgm_pkg::CMD_TERMINATE: begin
                if (!occupied[SB'(slot)]) r_ev <= rgm_pkg::EV_REJECT;
              end
              default: begin
                r_ev <= rgm_pkg::EV_REJECT;
                r_slot <= '0;
              end
            endcase
          end
        end
        rgm_pkg::ST_HELD_WR: begin
          // one kind step of launch, request, release or terminate
          case (cur_cmd)
            rgm_pkg::CMD_REQUEST: begin
              available_count[cur_kind] <= available_count[cur_kind] - 1'b1;
              r_ev <= rgm_pkg::EV_GRANTED;
              r_kind <= cur_kind;
            end
            rgm_pkg::CMD_RELEASE: begin
              r_kind <= cur_kind;
              if (mem_rdata != '0) begin
                available_count[cur_kind] <= sum_sat[CB] ? rgm_pkg::COUNT_MAX : sum_sat[CB-1:0];
                r_ev <= rgm_pkg::EV_RELEASED;
              end else begin
                r_ev <= rgm_pkg::EV_REL_IGN;
              end
            end
            rgm_pkg::CMD_TERMINATE: begin
              available_count[kcnt] <= sum_sat[CB] ? rgm_pkg::COUNT_MAX : sum_sat[CB-1:0];
              kcnt <= kcnt + 1'b1;
              if (kcnt == KB'(rgm_pkg::KINDS - 1)) begin
                occupied[cur_slot] <= 1'b0;
                blocked[cur_slot]  <= 1'b0;
                wanted_kind[cur_slot] <= '0;
                r_ev <= rgm_pkg::EV_TERM;
              end
            end
            default: kcnt <= kcnt + 1'b1;
          endcase
        end
        rgm_pkg::ST_UNBLK: begin
          if (!(occupied[sidx] && blocked[sidx] &&
                available_count[wanted_kind[sidx]] != '0)) begin
            sidx <= sidx + 1'b1;
            // the pick walk starts from a zero count
            scnt <= (scnt == (SB+1)'(rgm_pkg::SLOTS - 1)) ? '0 : scnt + 1'b1;
          end else begin
            cur_slot <= sidx;
            kcnt     <= wanted_kind[sidx];
          end
        end
        rgm_pkg::ST_UNBLK_WR: begin
          available_count[kcnt] <= available_count[kcnt] - 1'b1;
          blocked[cur_slot] <= 1'b0;
          wanted_kind[cur_slot] <= '0;
          r_ev   <= rgm_pkg::EV_UNBLOCK;
          r_slot <= 4'(cur_slot);
          r_kind <= kcnt;
          r_last <= 1'b0;
          sidx <= sidx + 1'b1;
          scnt <= (scnt == (SB+1)'(rgm_pkg::SLOTS - 1)) ? '0 : scnt + 1'b1;
        end
        rgm_pkg::ST_SCHED: begin
          r_kind <= '0;
          r_last <= 1'b1;
          if (scnt == '0) begin
            sidx <= next_pick;
            scnt <= (SB+1)'(1);
          end else if (occupied[sidx] && !blocked[sidx]) begin
            r_ev <= rgm_pkg::EV_SCHED;
            r_slot <= 4'(sidx);
            next_pick <= sidx + 1'b1;
          end else if (scnt == (SB+1)'(rgm_pkg::SLOTS)) begin
            r_ev <= rgm_pkg::EV_NONE;
            r_slot <= '0;
          end else begin
            sidx <= sidx + 1'b1;
            scnt <= scnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // remember where tick resumes after an unblock result
  always_ff @(posedge clk) begin
    if (state == rgm_pkg::ST_UNBLK_WR) begin
      after_out <= (scnt == (SB+1)'(rgm_pkg::SLOTS - 1)) ?
                   rgm_pkg::ST_SCHED : rgm_pkg::ST_UNBLK;
    end else if (state != rgm_pkg::ST_OUT) begin
      after_out <= rgm_pkg::ST_IDLE;
    end
  end

  // shared saturating adder: available count plus held count (or one)
  always_comb begin
    logic [CB-1:0] a, b;
    a = (cur_cmd == rgm_pkg::CMD_RELEASE) ? available_count[cur_kind] : available_count[kcnt];
    b = (cur_cmd == rgm_pkg::CMD_RELEASE) ? CB'(1) : mem_rdata;
    sum_sat = {1'b0, a} + {1'b0, b};
  end

  // next state and memory port
  always_comb begin
    logic [CB:0] inc;
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = addr_sk;
    mem_wdata  = '0;
    inc = {1'b0, mem_rdata} + 1'b1;
    case (state)
      rgm_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt[HB-1:0];
        if (clr_cnt == (HB+1)'(rgm_pkg::HELD_DEPTH - 1)) state_next = rgm_pkg::ST_IDLE;
      end
      rgm_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            rgm_pkg::CMD_LAUNCH:
              state_next = found_free ? rgm_pkg::ST_HELD_WR : rgm_pkg::ST_OUT;
            rgm_pkg::CMD_TICK: state_next = rgm_pkg::ST_UNBLK;
            rgm_pkg::CMD_REQUEST, rgm_pkg::CMD_RELEASE:
              state_next = (!occupied[SB'(slot)] || kind >= KB'(rgm_pkg::KINDS) ||
                            blocked[SB'(slot)] ||
                            (cmd == rgm_pkg::CMD_REQUEST &&
                             available_count[kind] == '0)) ?
                           rgm_pkg::ST_OUT : rgm_pkg::ST_HELD_RD;
            rgm_pkg::CMD_TERMINATE:
              state_next = occupied[SB'(slot)] ? rgm_pkg::ST_HELD_RD : rgm_pkg::ST_OUT;
            default: state_next = rgm_pkg::ST_OUT;
          endcase
        end
      end
      rgm_pkg::ST_HELD_RD: state_next = rgm_pkg::ST_HELD_WAIT;
      rgm_pkg::ST_HELD_WAIT: state_next = rgm_pkg::ST_HELD_WR;
      rgm_pkg::ST_HELD_WR: begin
        mem_we = 1'b1;
        case (cur_cmd)
          rgm_pkg::CMD_REQUEST: begin
            mem_wdata  = inc[CB] ? rgm_pkg::COUNT_MAX : inc[CB-1:0];
            state_next = rgm_pkg::ST_OUT;
          end
          rgm_pkg::CMD_RELEASE: begin
            mem_we     = (mem_rdata != '0);
            mem_wdata  = mem_rdata - 1'b1;
            state_next = rgm_pkg::ST_OUT;
          end
          rgm_pkg::CMD_TERMINATE:
            state_next = (kcnt == KB'(rgm_pkg::KINDS - 1)) ?
                         rgm_pkg::ST_OUT : rgm_pkg::ST_HELD_RD;
          default:
            state_next = (kcnt == KB'(rgm_pkg::KINDS - 1)) ?
                         rgm_pkg::ST_OUT : rgm_pkg::ST_HELD_WR;
        endcase
      end
      rgm_pkg::ST_UNBLK: begin
        if (occupied[sidx] && blocked[sidx] &&
            available_count[wanted_kind[sidx]] != '0)
          state_next = rgm_pkg::ST_UNBLK_RD;
        else if (scnt == (SB+1)'(rgm_pkg::SLOTS - 1))
          state_next = rgm_pkg::ST_SCHED;
      end
      rgm_pkg::ST_UNBLK_RD: state_next = rgm_pkg::ST_HELD_WAIT;
      rgm_pkg::ST_UNBLK_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = inc[CB] ? rgm_pkg::COUNT_MAX : inc[CB-1:0];
        state_next = rgm_pkg::ST_OUT;
      end
      rgm_pkg::ST_SCHED: begin
        if (scnt != '0 && ((occupied[sidx] && !blocked[sidx]) ||
                           scnt == (SB+1)'(rgm_pkg::SLOTS)))
          state_next = rgm_pkg::ST_OUT;
      end
      rgm_pkg::ST_OUT: if (out_ready) state_next = after_out;
      default: state_next = rgm_pkg::ST_IDLE;
    endcase
    // unblock path reuses the read wait, then branches to its own write
    if (state == rgm_pkg::ST_HELD_WAIT && cur_cmd == rgm_pkg::CMD_TICK)
      state_next = rgm_pkg::ST_UNBLK_WR;
    if (rst) state_next = rgm_pkg::ST_CLEAR;
  end

endmodule

@@ design/rgm_checker.sv @@
// rgm_checker: port-level checks for resource_grant_manager
// depends on rgm_pkg; bound to the top level below

module rgm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] event_res,
  input logic [3:0] which_kind,
  input logic       last
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res))
    else $error("result dropped");

  a_unblock_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == rgm_pkg::EV_UNBLOCK |-> !last)
    else $error("unblock grant marked last");

  a_kind_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == rgm_pkg::EV_REJECT || event_res == rgm_pkg::EV_SCHED ||
                  event_res == rgm_pkg::EV_TERM) |-> which_kind == 4'd0)
    else $error("kind on kindless event");

endmodule

bind resource_grant_manager rgm_checker u_rgm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .event_res(event_res),
  .which_kind(which_kind), .last(last)
);

@@ sim/rgm_event_checker.sv @@
`timescale 1ns / 100ps
// rgm_event_checker: watches the item and result channels of the resource grant
// manager, predicts every result item and compares; depends on rgm_pkg

module rgm_event_checker
  import rgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] cmd,
  input  logic [3:0] slot,
  input  logic [3:0] kind,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] event_res,
  input  logic [3:0] which_slot,
  input  logic [3:0] which_kind,
  input  logic       last,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    event_t     ev;
    logic [3:0] s;
    logic [3:0] k;
    logic       fin;
  } grant_event_t;

  grant_event_t expected_events[$];

  // shadow of the slot table and the pool
  logic                  occ_m [SLOTS];
  logic                  blk_m [SLOTS];
  logic [3:0]            want_m [SLOTS];
  logic [COUNT_BITS-1:0] held_m [SLOTS][KINDS];
  logic [COUNT_BITS-1:0] avail_m [KINDS];
  logic [3:0]            pick_m;

  function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a,
                                                    logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] sum;
    sum = a + b;
    return sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
  endfunction

  task automatic push_event(event_t ev, logic [3:0] s, logic [3:0] k);
    grant_event_t e;
    e.ev = ev; e.s = s; e.k = k; e.fin = 1'b0;
    expected_events.push_back(e);
  endtask

  task automatic predict_grants(logic [2:0] c, logic [3:0] s, logic [3:0] k);
    int    first_free;
    logic  slot_ok;
    logic  found;
    int    i;
    int    n0;
    n0 = expected_events.size();
    slot_ok = occ_m[s];
    case (c)
      CMD_LAUNCH: begin
        first_free = -1;
        for (int j = SLOTS - 1; j >= 0; j--) if (!occ_m[j]) first_free = j;
        if (first_free < 0) push_event(EV_FULL, 0, 0);
        else begin
          occ_m[first_free] = 1'b1;
          blk_m[first_free] = 1'b0;
          want_m[first_free] = '0;
          for (int r = 0; r < KINDS; r++) held_m[first_free][r] = '0;
          push_event(EV_LAUNCHED, first_free[3:0], 0);
        end
      end
      CMD_TICK: begin
        // blocked slots first, in slot order
        for (int j = 0; j < SLOTS; j++) begin
          if (occ_m[j] && blk_m[j] && want_m[j] < KINDS && avail_m[want_m[j]] != 0) begin
            avail_m[want_m[j]]--;
            held_m[j][want_m[j]] = sat_add(held_m[j][want_m[j]], 1);
            blk_m[j] = 1'b0;
            push_event(EV_UNBLOCK, j[3:0], want_m[j]);
            want_m[j] = '0;
          end
        end
        found = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
          i = (pick_m + j) % SLOTS;
          if (!found && occ_m[i] && !blk_m[i]) begin
            found = 1'b1;
            pick_m = (i + 1) % SLOTS;
            push_event(EV_SCHED, i[3:0], 0);
          end
        end
        if (!found) push_event(EV_NONE, 0, 0);
      end
      CMD_REQUEST: begin
        if (!slot_ok || k >= KINDS || blk_m[s]) push_event(EV_REJECT, s, 0);
        else if (avail_m[k] != 0) begin
          avail_m[k]--;
          held_m[s][k] = sat_add(held_m[s][k], 1);
          push_event(EV_GRANTED, s, k);
        end else begin
          blk_m[s] = 1'b1;
          want_m[s] = k;
          push_event(EV_BLOCKED, s, k);
        end
      end
      CMD_RELEASE: begin
        if (!slot_ok || k >= KINDS || blk_m[s]) push_event(EV_REJECT, s, 0);
        else if (held_m[s][k] != 0) begin
          held_m[s][k]--;
          avail_m[k] = sat_add(avail_m[k], 1);
          push_event(EV_RELEASED, s, k);
        end else push_event(EV_REL_IGN, s, k);
      end
      CMD_TERMINATE: begin
        if (!slot_ok) push_event(EV_REJECT, s, 0);
        else begin
          for (int r = 0; r < KINDS; r++) begin
            avail_m[r] = sat_add(avail_m[r], held_m[s][r]);
            held_m[s][r] = '0;
          end
          occ_m[s] = 1'b0;
          blk_m[s] = 1'b0;
          want_m[s] = '0;
          push_event(EV_TERM, s, 0);
        end
      end
      default: push_event(EV_REJECT, 0, 0);
    endcase
    if (expected_events.size() > n0) expected_events[$].fin = 1'b1;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    grant_event_t e;
    if (rst) begin
      expected_events.delete();
      for (int j = 0; j < SLOTS; j++) begin
        occ_m[j] = 1'b0;
        blk_m[j] = 1'b0;
        want_m[j] = '0;
        for (int r = 0; r < KINDS; r++) held_m[j][r] = '0;
      end
      for (int r = 0; r < KINDS; r++) avail_m[r] = 8'd20;
      pick_m = '0;
    end else begin
      // register write reloads the pool, held counts stay
      if (cfg_we) for (int r = 0; r < KINDS; r++) avail_m[r] = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected result event_res", event_res, -1);
        end else begin
          e = expected_events.pop_front();
          if (event_res != e.ev) report_mismatch("event_res", event_res, e.ev);
          if (which_slot != e.s) report_mismatch("which_slot", which_slot, e.s);
          if (which_kind != e.k) report_mismatch("which_kind", which_kind, e.k);
          if (last != e.fin) report_mismatch("last", last, e.fin);
        end
      end
      if (in_valid && in_ready) predict_grants(cmd, slot, kind);
    end
    pending = expected_events.size();
  end

endmodule

@@ sim/tb_resource_grant_manager.sv @@
`timescale 1ns / 100ps
// tb_resource_grant_manager: stimulus and verdict for the resource grant manager
// depends on rgm_pkg, resource_grant_manager and rgm_event_checker

module tb_resource_grant_manager;
  import rgm_pkg::*;

  localparam int QUIET_LIMIT = 5000;  // cycles with no handshake before giving up
  localparam int DRAIN_WAIT  = 200;   // covers the longest tick walk

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] cmd;
  logic [3:0] slot;
  logic [3:0] kind;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] event_res;
  logic [3:0] which_slot;
  logic [3:0] which_kind;
  logic       last;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         quiet_cycles;

  resource_grant_manager dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .slot(slot), .kind(kind),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .which_slot(which_slot), .which_kind(which_kind),
    .last(last),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  rgm_event_checker u_event_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .slot(slot), .kind(kind),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_res(event_res), .which_slot(which_slot), .which_kind(which_kind),
    .last(last),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // receiver stalls at random, changes only on the falling edge
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // watchdog: any handshake on either side resets the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_resource_grant_manager failed");
      $finish;
    end
  end

  // present one item and hold it until taken; in_ready is sampled at each
  // rising edge, the edge at which the block takes the item
  task automatic send_item(logic [2:0] c, logic [3:0] s, logic [3:0] k);
    logic taken;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    slot <= s;
    kind <= k;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
      @(negedge clk);
    end
  endtask

  // idle block only: wait for all results, then a tick walk more
  task automatic write_instances(logic [7:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed traffic on the low slots and a few kinds, so that
  // grants run dry and slots block; the rest is any value at all
  task automatic run_traffic(int count);
    int         pick;
    logic [2:0] c;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 80) begin
        pick = $urandom_range(99);
        if (pick < 20)      c = CMD_LAUNCH;
        else if (pick < 45) c = CMD_TICK;
        else if (pick < 75) c = CMD_REQUEST;
        else if (pick < 90) c = CMD_RELEASE;
        else                c = CMD_TERMINATE;
        send_item(c, 4'($urandom_range(0, 5)), 4'($urandom_range(0, 3)));
      end else begin
        send_item(3'($urandom_range(7)), 4'($urandom_range(15)), 4'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_LAUNCH;
    slot = '0;
    kind = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    tx_idle_pct = 13;
    rx_idle_pct = 67;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: empty table, unknown commands, filling up, bad kind, empty release, terminate
    send_item(CMD_TICK, 0, 0);                 // nothing runnable
    send_item(CMD_REQUEST, 15, 9);             // slot not occupied
    send_item(3'd7, 15, 15);                   // unknown command
    send_item(3'd5, 0, 0);
    send_item(3'd6, 0, 0);
    for (int j = 0; j < SLOTS; j++) send_item(CMD_LAUNCH, 0, 0);
    send_item(CMD_LAUNCH, 0, 0);               // table full
    send_item(CMD_REQUEST, 0, 15);             // bad kind
    send_item(CMD_RELEASE, 0, 0);              // nothing held
    send_item(CMD_TERMINATE, 3, 0);

    // one instance per kind: lots of blocking and unblock grants
    write_instances(8'd1);
    run_traffic(155);

    // saturated pool, releases pile onto a full count
    tx_idle_pct = 67;
    rx_idle_pct = 13;
    write_instances(8'd255);
    run_traffic(155);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_instances(8'($urandom_range(2, 254)));
    run_traffic(155);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_resource_grant_manager passed");
    end else begin
      $display("tb_resource_grant_manager failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/rgm_pkg.sv
design/resource_grant_manager.sv
design/rgm_checker.sv
sim/rgm_event_checker.sv
sim/tb_resource_grant_manager.sv
